// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`endif

// File: rtl/phhc_pkg.sv
// ----------------------------------------------------------------------------
// phhc_pkg
// Types, constants and helper functions for the predictive heater control.
// ----------------------------------------------------------------------------
package phhc_pkg;

   // Field widths.
   localparam int TEMP_W      = 12;
   localparam int GAIN_W      = 6;
   localparam int HYST_W      = 8;
   localparam int RATE_W      = 13;
   localparam int PRED_W      = 20;
   localparam int COUNT_W     = 4;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 24;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 12;

   // Register indexes on the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_SETPOINT   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN       = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_HYSTERESIS = 2'd2;

   // Register reset values.
   localparam logic [TEMP_W-1:0] SETPOINT_RST   = 12'd0;
   localparam logic [GAIN_W-1:0] GAIN_RST       = 6'd10;
   localparam logic [HYST_W-1:0] HYSTERESIS_RST = 8'd20;

   // Stall throttle limits.
   localparam logic signed [RATE_W-1:0]  RATE_STALL_MAX = 13'sd2;
   localparam logic signed [COUNT_W-1:0] THROTTLE_START = 4'sd4;
   localparam logic signed [COUNT_W-1:0] THROTTLE_END   = -4'sd3;

   // Divide by three through a reciprocal: (g * 43) >> 7 is exact for g below 128.
   localparam int GAIN_DIV3_MUL   = 43;
   localparam int GAIN_DIV3_SHIFT = 7;
   localparam int GAIN_DIV3_W     = 12;

   // Decision codes reported with each result word.
   typedef enum logic [1:0] {
      DEC_HOLD = 2'd0,
      DEC_OFF  = 2'd1,
      DEC_ON   = 2'd2
   } decision_type;

   // Configuration register set.
   typedef struct packed {
      logic [TEMP_W-1:0] setpoint;
      logic [GAIN_W-1:0] predict_gain;
      logic [HYST_W-1:0] hysteresis;
   } cfg_type;

   // One result word; heater_on lands in the lowest bit when packed.
   typedef struct packed {
      logic signed [RATE_W-1:0] temp_rate;
      logic                     throttle_active;
      decision_type             decision;
      logic                     heater_on;
   } result_type;

   // Gain divided by three, rounded down.
   function automatic logic [GAIN_W-2:0] gain_div3(input logic [GAIN_W-1:0] gain);
      logic [GAIN_DIV3_W-1:0] prod;
      prod = GAIN_DIV3_W'(gain) * GAIN_DIV3_W'(GAIN_DIV3_MUL);
      return prod[GAIN_DIV3_SHIFT +: (GAIN_W-1)];
   endfunction

endpackage

// File: rtl/predictive_hysteresis_heater_control.sv
// ----------------------------------------------------------------------------
// predictive_hysteresis_heater_control
// Bang-bang heater control with a predictive dead band and stall throttle.
//
//   Channel  Direction  Word contents (lowest bit first)
//   req_     in         measured_temp[11:0], zero pad to 16 bits
//   rsp_     out        heater_on, decision[1:0], throttle_active,
//                       temp_rate[12:0], zero pad to 24 bits
//   csr_     in         write enable, register index, write data
//
// One word per cycle is accepted and returned while rsp_ does not stall.
// An accepted word passes through the input register and then the result
// register, which offers it on rsp_.
// Reset is synchronous: registers return to their defaults, the heater is
// off and both stages empty. A stall on rsp_ holds the result register and
// the input register still takes one more word before req_tready drops.
// ----------------------------------------------------------------------------
module predictive_hysteresis_heater_control (
   input  logic                             clock,
   input  logic                             reset,
   // measured_temp[11:0]
   input  logic [phhc_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // heater_on, decision[1:0], throttle_active, temp_rate[12:0]
   output logic [phhc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_we,
   input  logic [phhc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [phhc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import phhc_pkg::*;

   cfg_type           cfg;
   result_type        result;

   logic              in_vld_ff;
   logic              in_vld_in;
   logic [TEMP_W-1:0] in_temp_ff;
   logic              out_vld_ff;
   logic              out_vld_in;
   result_type        out_data_ff;
   logic              out_load;
   logic              fire;
   logic              accept;

   phhc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   phhc_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .temp   (in_temp_ff),
      .cfg    (cfg),
      .result (result)
   );

   // Handshake: the result register loads when empty or being drained.
   assign out_load   = !out_vld_ff || rsp_tready;
   assign fire       = in_vld_ff && out_load;
   assign req_tready = !in_vld_ff || out_load;
   assign accept     = req_tvalid && req_tready;

   assign in_vld_in  = accept ? 1'b1 : (fire ? 1'b0 : in_vld_ff);
   assign out_vld_in = out_load ? in_vld_ff : out_vld_ff;

   // Stage valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (accept) begin
         in_temp_ff <= req_tdata[TEMP_W-1:0];
      end
      if (fire) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = {(RSP_TDATA_W - $bits(result_type))'(0), out_data_ff};

endmodule

// File: rtl/phhc_csr.sv
// ----------------------------------------------------------------------------
// phhc_csr
// Configuration registers written through the plain write port.
// ----------------------------------------------------------------------------
module phhc_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [phhc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [phhc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output phhc_pkg::cfg_type                cfg
);
   import phhc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write; an unknown index leaves everything as it is.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SETPOINT:   cfg_in.setpoint     = csr_wdata[TEMP_W-1:0];
            CSR_GAIN:       cfg_in.predict_gain = csr_wdata[GAIN_W-1:0];
            CSR_HYSTERESIS: cfg_in.hysteresis   = csr_wdata[HYST_W-1:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.setpoint     <= SETPOINT_RST;
         cfg_ff.predict_gain <= GAIN_RST;
         cfg_ff.hysteresis   <= HYSTERESIS_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/phhc_core.sv
// ----------------------------------------------------------------------------
// phhc_core
// Rate, prediction, dead band decision and stall throttle for one sample.
// ----------------------------------------------------------------------------
module phhc_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        fire,
   input  logic [phhc_pkg::TEMP_W-1:0] temp,
   input  phhc_pkg::cfg_type           cfg,
   output phhc_pkg::result_type        result
);
   import phhc_pkg::*;

   // Controller state.
   logic [TEMP_W-1:0]         prev_temp_ff;
   logic [TEMP_W-1:0]         prev_temp_in;
   logic                      first_ff;
   logic                      first_in;
   logic                      throttling_ff;
   logic                      throttling_in;
   logic signed [COUNT_W-1:0] count_ff;
   logic signed [COUNT_W-1:0] count_in;
   logic                      heater_ff;
   logic                      heater_in;

   logic [TEMP_W-1:0]         prev_eff;
   logic signed [RATE_W-1:0]  rate;
   logic [GAIN_W-1:0]         gain_sel;
   logic signed [PRED_W-1:0]  prod;
   logic signed [PRED_W-1:0]  pred;
   logic signed [PRED_W-1:0]  band_hi;
   logic signed [PRED_W-1:0]  band_lo;
   logic signed [PRED_W-1:0]  half;
   logic signed [PRED_W-1:0]  sp;
   logic                      req_off;
   logic                      req_on;
   logic                      force_off;
   logic signed [COUNT_W-1:0] count_dec;
   logic signed [COUNT_W-1:0] count_inc;
   decision_type              decision;

   // Rate since the last sample; the first sample counts as unchanged.
   assign prev_eff = first_ff ? temp : prev_temp_ff;
   assign rate     = signed'({1'b0, temp}) - signed'({1'b0, prev_eff});

   // Extrapolate with the full gain when rising, a third of it when falling.
   assign gain_sel = rate[RATE_W-1] ? {1'b0, gain_div3(cfg.predict_gain)} : cfg.predict_gain;
   assign prod     = PRED_W'(rate) * PRED_W'(signed'({1'b0, gain_sel}));
   assign pred     = prod + PRED_W'(signed'({1'b0, temp}));

   // Dead band of half the hysteresis on each side of the setpoint.
   assign sp      = PRED_W'(signed'({1'b0, cfg.setpoint}));
   assign half    = PRED_W'(signed'({1'b0, cfg.hysteresis[HYST_W-1:1]}));
   assign band_hi = sp + half;
   assign band_lo = sp - half;
   assign req_off = pred > band_hi;
   assign req_on  = !req_off && (pred < band_lo);

   // Stall throttle: counts low-rate samples while not asked off, then holds off.
   assign count_dec = count_ff - 4'sd1;
   assign count_inc = count_ff + 4'sd1;

   always_comb begin
      throttling_in = throttling_ff;
      count_in      = count_ff;
      priority if (req_off) begin
         throttling_in = 1'b0;
         count_in      = '0;
      end else if (throttling_ff) begin
         throttling_in = count_dec > THROTTLE_END;
         count_in      = (count_dec > THROTTLE_END) ? count_dec : '0;
      end else if (rate <= RATE_STALL_MAX) begin
         throttling_in = count_inc >= THROTTLE_START;
         count_in      = count_inc;
      end else begin
         count_in = '0;
      end
   end

   // Heater drive and the reported decision.
   assign force_off = req_off || throttling_in;

   always_comb begin
      priority if (force_off) begin
         heater_in = 1'b0;
         decision  = DEC_OFF;
      end else if (req_on) begin
         heater_in = 1'b1;
         decision  = DEC_ON;
      end else begin
         heater_in = heater_ff;
         decision  = DEC_HOLD;
      end
   end

   assign prev_temp_in = temp;
   assign first_in     = 1'b0;

   // State advances once per sample handed on to the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_temp_ff  <= '0;
         first_ff      <= 1'b1;
         throttling_ff <= 1'b0;
         count_ff      <= '0;
         heater_ff     <= 1'b0;
      end else if (fire) begin
         prev_temp_ff  <= prev_temp_in;
         first_ff      <= first_in;
         throttling_ff <= throttling_in;
         count_ff      <= count_in;
         heater_ff     <= heater_in;
      end
   end

   assign result.temp_rate       = rate;
   assign result.throttle_active = throttling_in;
   assign result.decision        = decision;
   assign result.heater_on       = heater_in;

endmodule

// File: rtl/phhc_checker.sv
// ----------------------------------------------------------------------------
// phhc_checker
// Port-level checks on the result channel of the heater control.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module phhc_checker (
   input logic                             clock,
   input logic                             reset,
   input logic [phhc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready
);
   import phhc_pkg::*;

   logic       heater_on;
   logic [1:0] decision;
   logic       throttle_active;

   assign heater_on       = rsp_tdata[0];
   assign decision        = rsp_tdata[2:1];
   assign throttle_active = rsp_tdata[3];

   // A stalled result word stays put.
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))

   // Switching on drives the heater and never happens while throttled.
   `ASSERT_IMPLIES(a_on_drives, clock, reset, rsp_tvalid && (decision == DEC_ON),
      heater_on && !throttle_active)

   // Switching off leaves the heater off.
   `ASSERT_IMPLIES(a_off_drives, clock, reset, rsp_tvalid && (decision == DEC_OFF),
      !heater_on)

   // Throttling always reports an off decision.
   `ASSERT_IMPLIES(a_throttle_off, clock, reset, rsp_tvalid && throttle_active,
      (decision == DEC_OFF) && !heater_on)

endmodule

bind predictive_hysteresis_heater_control phhc_checker u_phhc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

// File: test/heater_result_check.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// heater_result_check
// Watches the temperature, result and register ports of the heater control.
// Each accepted temperature word is run through a local model of the
// controller. The result words that come back are compared with the model,
// field by field and in order.
// ----------------------------------------------------------------------------
module heater_result_check (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [phhc_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  logic                             req_tvalid,
   input  logic                             req_tready,
   input  logic [phhc_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   input  logic                             csr_we,
   input  logic [phhc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [phhc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output int                               mismatches,
   output int                               outstanding
);
   import phhc_pkg::*;

   // Register values after reset.
   localparam logic [TEMP_W-1:0] SETPOINT_AT_RESET = 12'd0;
   localparam logic [GAIN_W-1:0] GAIN_AT_RESET     = 6'd10;
   localparam logic [HYST_W-1:0] HYST_AT_RESET     = 8'd20;

   // Stall throttle limits.
   localparam int STALL_RATE_MAX     = 2;
   localparam int THROTTLE_ON_COUNT  = 4;
   localparam int THROTTLE_OFF_COUNT = -3;

   // Only the first mismatches are printed; all of them are counted.
   localparam int MAX_PRINTED = 60;

   // Register copies.
   logic [TEMP_W-1:0] setpoint;
   logic [GAIN_W-1:0] gain;
   logic [HYST_W-1:0] hyst;

   // Controller state.
   logic [TEMP_W-1:0]         last_temp;
   logic                      first_tick;
   logic                      throttling;
   logic signed [COUNT_W-1:0] stall_count;
   logic                      heater;

   // Result words predicted but not yet returned, oldest first.
   result_type expected_words[$];
   int         mismatch_count = 0;

   assign mismatches = mismatch_count;

   task automatic report(input string what, input int got, input int want);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED) begin
         $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
      end
   endtask

   // Advances the controller state by one tick and returns its result word.
   function automatic result_type predict_heater(input logic [TEMP_W-1:0] temp);
      result_type               word;
      logic signed [RATE_W-1:0] rate;
      decision_type             request;
      int                       eff_gain;
      int                       forecast;
      int                       half_band;
      int                       count;
      // The first tick has no history, so its rate is zero.
      if (first_tick) begin
         last_temp  = temp;
         first_tick = 1'b0;
      end
      rate      = $signed({1'b0, temp}) - $signed({1'b0, last_temp});
      last_temp = temp;

      // A falling temperature is extrapolated with a third of the gain.
      eff_gain  = (rate < 0) ? int'(gain) / 3 : int'(gain);
      forecast  = int'(temp) + int'(rate) * eff_gain;
      half_band = int'(hyst) / 2;
      if (forecast > int'(setpoint) + half_band) begin
         request = DEC_OFF;
      end else if (forecast < int'(setpoint) - half_band) begin
         request = DEC_ON;
      end else begin
         request = DEC_HOLD;
      end

      // Stall throttle: a temperature that stops rising forces a spell of off.
      count = int'(stall_count);
      if (request == DEC_OFF) begin
         throttling = 1'b0;
         count      = 0;
      end else if (throttling) begin
         count      = count - 1;
         throttling = count > THROTTLE_OFF_COUNT;
         if (!throttling) begin
            count = 0;
         end
      end else if (int'(rate) <= STALL_RATE_MAX) begin
         count      = count + 1;
         throttling = count >= THROTTLE_ON_COUNT;
      end else begin
         count = 0;
      end
      stall_count = COUNT_W'(count);
      if (throttling) begin
         request = DEC_OFF;
      end

      if (request == DEC_OFF) begin
         heater = 1'b0;
      end else if (request == DEC_ON) begin
         heater = 1'b1;
      end

      word.heater_on       = heater;
      word.decision        = request;
      word.throttle_active = throttling;
      word.temp_rate       = rate;
      return word;
   endfunction

   // Results are checked before the new word is predicted, since a word
   // accepted in this cycle can only come back in a later one.
   always @(posedge clock) begin : watch
      result_type got;
      result_type want;
      if (reset) begin
         setpoint    = SETPOINT_AT_RESET;
         gain        = GAIN_AT_RESET;
         hyst        = HYST_AT_RESET;
         last_temp   = '0;
         first_tick  = 1'b1;
         throttling  = 1'b0;
         stall_count = '0;
         heater      = 1'b0;
         expected_words.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(result_type)-1:0];
            if (rsp_tdata[RSP_TDATA_W-1:$bits(result_type)] != '0) begin
               report("result word padding", int'(rsp_tdata[RSP_TDATA_W-1:$bits(result_type)]),
                      0);
            end
            if (expected_words.size() == 0) begin
               report("result word with none pending", int'(got), 0);
            end else begin
               want = expected_words.pop_front();
               if (got.heater_on !== want.heater_on) begin
                  report("heater_on", int'(got.heater_on), int'(want.heater_on));
               end
               if (got.decision !== want.decision) begin
                  report("decision", int'(got.decision), int'(want.decision));
               end
               if (got.throttle_active !== want.throttle_active) begin
                  report("throttle_active", int'(got.throttle_active),
                         int'(want.throttle_active));
               end
               if (got.temp_rate !== want.temp_rate) begin
                  report("temp_rate", int'(got.temp_rate), int'(want.temp_rate));
               end
            end
         end

         if (req_tvalid && req_tready) begin
            expected_words.push_back(predict_heater(req_tdata[TEMP_W-1:0]));
         end

         // Bits above a register's width are dropped; other indexes do nothing.
         if (csr_we) begin
            case (csr_index)
               CSR_SETPOINT: begin
                  setpoint = csr_wdata[TEMP_W-1:0];
               end
               CSR_GAIN: begin
                  gain = csr_wdata[GAIN_W-1:0];
               end
               CSR_HYSTERESIS: begin
                  hyst = csr_wdata[HYST_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
      outstanding <= expected_words.size();
   end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps

// ----------------------------------------------------------------------------
// testbench
// Drives the predictive heater control with temperature words and register
// settings. A short directed run covers the rate extremes, every decision,
// a full stall throttle spell, masked register bits and the unused register
// index. Random phases then follow, each with its own register setting, with
// temperature walks around the setpoint. Both channels idle at random, and
// the result side holds off for long stretches so that the block backs up.
// The result check module does the comparing.
// ----------------------------------------------------------------------------
module testbench;
   import phhc_pkg::*;

   // Register index that selects no register.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   // Idle patterns for either side.
   localparam int PACE_FULL   = 0;
   localparam int PACE_RANDOM = 1;
   localparam int PACE_BURSTY = 2;
   localparam int MAX_GAP     = 18;

   localparam int TEMP_MAX      = (1 << TEMP_W) - 1;
   localparam int PAD_W         = REQ_TDATA_W - TEMP_W;
   localparam int RANDOM_PHASES = 11;
   localparam int PHASE_WORDS   = 150;
   localparam int STALL_WORD_A  = 500;
   localparam int STALL_WORD_B  = 1200;
   localparam int LONG_STALL    = 300;
   localparam int TIMEOUT_NS    = 2_000_000;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   int mismatches;
   int outstanding;
   int send_pace = PACE_FULL;
   int take_pace = PACE_FULL;
   int words_taken = 0;

   always begin
      #2;
      clock = 1'b1;
      #2;
      clock = 1'b0;
   end

   predictive_hysteresis_heater_control dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   heater_result_check result_check (
      .clock       (clock),
      .reset       (reset),
      .req_tdata   (req_tdata),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   function automatic int draw_gap(input int pace);
      case (pace)
         PACE_FULL: begin
            return 0;
         end
         PACE_RANDOM: begin
            return $urandom_range(0, MAX_GAP);
         end
         default: begin
            return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_GAP) : 0;
         end
      endcase
   endfunction

   // A register value: zero, all ones or random, with junk above the width
   // now and then, which the block must drop.
   function automatic logic [CSR_DATA_W-1:0] pick_reg(input int width);
      logic [CSR_DATA_W-1:0] mask;
      logic [CSR_DATA_W-1:0] value;
      mask = CSR_DATA_W'((1 << width) - 1);
      case ($urandom_range(0, 4))
         0: begin
            value = '0;
         end
         1: begin
            value = mask;
         end
         default: begin
            value = CSR_DATA_W'($urandom) & mask;
         end
      endcase
      if ($urandom_range(0, 3) == 0) begin
         value = value | (CSR_DATA_W'($urandom) & ~mask);
      end
      return value;
   endfunction

   // Offers one temperature word after the drawn gap and waits until it is taken.
   task automatic send_temp(input logic [TEMP_W-1:0] temp, input logic [PAD_W-1:0] pad);
      int gap;
      gap = draw_gap(send_pace);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= {pad, temp};
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops offering and waits until every predicted word has come back.
   task automatic drain;
      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_registers(input logic [CSR_DATA_W-1:0] sp_word,
                                input logic [CSR_DATA_W-1:0] gain_word,
                                input logic [CSR_DATA_W-1:0] hyst_word,
                                input bit                    touch_unused);
      csr_we    <= 1'b1;
      csr_index <= CSR_SETPOINT;
      csr_wdata <= sp_word;
      @(posedge clock);
      csr_index <= CSR_GAIN;
      csr_wdata <= gain_word;
      @(posedge clock);
      csr_index <= CSR_HYSTERESIS;
      csr_wdata <= hyst_word;
      @(posedge clock);
      if (touch_unused) begin
         csr_index <= CSR_UNUSED;
         csr_wdata <= CSR_DATA_W'($urandom);
         @(posedge clock);
      end
      csr_we <= 1'b0;
   endtask

   // Temperature walk around the setpoint: drifts, stalls that feed the
   // throttle, and now and then a jump anywhere or to an extreme.
   task automatic run_phase(input logic [TEMP_W-1:0] setpoint_now);
      int                     walk;
      int                     heading;
      int                     pick;
      logic [PAD_W-1:0]       pad;
      walk    = int'(setpoint_now) + int'($urandom_range(0, 80)) - 40;
      heading = 1;
      send_pace = $urandom_range(PACE_FULL, PACE_BURSTY);
      repeat (PHASE_WORDS) begin
         if ($urandom_range(0, 39) == 0) begin
            send_pace = $urandom_range(PACE_FULL, PACE_BURSTY);
         end
         if ($urandom_range(0, 15) == 0) begin
            heading = -heading;
         end
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            walk = $urandom_range(0, TEMP_MAX);
         end else if (pick == 1) begin
            walk = ($urandom_range(0, 1) != 0) ? TEMP_MAX : 0;
         end else if (pick < 8) begin
            walk = walk + int'($urandom_range(0, 3)) - 1;
         end else begin
            walk = walk + heading * int'($urandom_range(0, 8));
         end
         if (walk < 0) begin
            walk = 0;
         end else if (walk > TEMP_MAX) begin
            walk = TEMP_MAX;
         end
         pad = ($urandom_range(0, 15) == 0) ? PAD_W'($urandom_range(1, 15)) : '0;
         send_temp(TEMP_W'(walk), pad);
      end
   endtask

   // Stimulus and verdict.
   initial begin : stimulus
      logic [CSR_DATA_W-1:0] sp_word;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Registers at reset: first tick, largest rise, largest fall, and a
      // word with junk in its padding.
      send_temp(12'd0, '0);
      send_temp(12'd4095, '0);
      send_temp(12'd0, '0);
      send_temp(12'd5, 4'hF);

      // Highest setpoint, no gain and no dead band, written with junk bits
      // above the gain and hysteresis widths. A steady temperature runs one
      // whole throttle spell; the last two words give a hold and a switch on.
      drain;
      set_registers(12'd4095, 12'hFC0, 12'hF00, 1'b1);
      repeat (14) send_temp(12'd100, '0);
      send_temp(12'd4095, '0);
      send_temp(12'd4094, '0);

      // Largest gain and dead band: on after the fall from the last word,
      // then off on a rise, on on a fall and off on a rise.
      drain;
      set_registers(12'd2048, 12'd63, 12'd255, 1'b0);
      send_temp(12'd2000, '0);
      send_temp(12'd2010, '0);
      send_temp(12'd2005, '0);
      send_temp(12'd2048, '0);

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         drain;
         sp_word = pick_reg(TEMP_W);
         set_registers(sp_word, pick_reg(GAIN_W), pick_reg(HYST_W),
                       $urandom_range(0, 3) == 0);
         run_phase(sp_word[TEMP_W-1:0]);
      end

      req_tvalid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (8) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Result side: random readiness, with two long hold-offs while the
   // sender keeps offering words.
   initial begin : receiver
      int gap;
      @(posedge clock);
      forever begin
         if (words_taken == STALL_WORD_A || words_taken == STALL_WORD_B) begin
            rsp_tready <= 1'b0;
            repeat (LONG_STALL) @(posedge clock);
         end
         if ($urandom_range(0, 39) == 0) begin
            take_pace = $urandom_range(PACE_FULL, PACE_BURSTY);
         end
         gap = draw_gap(take_pace);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         words_taken++;
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
